// ----- rtl/gfn_pkg.sv -----
package gfn_pkg;

	localparam int MAX_DETECTORS = 1024;
	localparam int MAX_GEO_ROWS  = 8;
	localparam int DIV_STEPS = 32;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_APPLY  = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	localparam logic REG_RING  = 1'b0;
	localparam logic REG_BLOCK = 1'b1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [9:0]  det_a;
		logic [10:0] det_b;
		logic [31:0] pair_value;
		logic [2:0]  table_row;
		logic [9:0]  table_col;
		logic [31:0] table_word;
	} item_t;

	typedef struct packed {
		logic [10:0] ring;
		logic [4:0]  block;
	} cfg_t;

	typedef struct packed {
		item_t       item;
		logic [4:0]  pos;
		logic        neg;
		logic [10:0] rem;
	} addr_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] value;
		logic [31:0] factor;
	} operand_t;

	typedef struct packed {
		logic        active;
		logic [31:0] f;
		logic [31:0] rem;
		logic [31:0] dq;
		logic [31:0] res;
		logic [1:0]  st;
	} div_t;

	// Rounded-up reciprocal of an even block size, scaled by 2^16.
	function automatic logic [15:0] block_recip(input logic [4:0] c);
		logic [15:0] r;
		case (c)
			5'd2:    r = 16'd32768;
			5'd4:    r = 16'd16384;
			5'd6:    r = 16'd10923;
			5'd8:    r = 16'd8192;
			5'd10:   r = 16'd6554;
			5'd12:   r = 16'd5462;
			5'd14:   r = 16'd4682;
			5'd16:   r = 16'd4096;
			5'd18:   r = 16'd3641;
			5'd20:   r = 16'd3277;
			5'd22:   r = 16'd2979;
			5'd24:   r = 16'd2731;
			5'd26:   r = 16'd2521;
			5'd28:   r = 16'd2341;
			5'd30:   r = 16'd2185;
			default: r = 16'd32768;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/gfn_if.sv -----
interface gfn_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [9:0]  det_a;
	logic [10:0] det_b;
	logic [31:0] pair_value;
	logic [2:0]  table_row;
	logic [9:0]  table_col;
	logic [31:0] table_word;

	modport source (output valid, cmd, det_a, det_b, pair_value, table_row, table_col,
		table_word, input ready);
	modport sink (input valid, cmd, det_a, det_b, pair_value, table_row, table_col,
		table_word, output ready);
endinterface

interface gfn_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_value;
	logic [1:0]  out_status;

	modport source (output valid, out_value, out_status, input ready);
	modport sink (input valid, out_value, out_status, output ready);
endinterface

// ----- rtl/gfn_ram.sv -----
module gfn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/gfn_addr.sv -----
module gfn_addr
	import gfn_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output addr_t out_addr
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        r1, r2, r3, r4;
	item_t       item_s1, item_s2, item_s3, item_s4;
	logic [9:0]  q_s1;
	logic [4:0]  pos_s2, pos_s3, pos_s4;
	logic        neg_s2, neg_s3, neg_s4;
	logic [11:0] mag_s2, mag_s3;
	logic [10:0] rem_s4;

	logic [25:0]        prod;
	logic [14:0]        qc;
	logic [9:0]         pos_full;
	logic [4:0]         cm1;
	logic [4:0]         pos_m;
	logic               mirror;
	logic signed [12:0] nb;
	logic signed [12:0] nb_f;
	logic [12:0]        nb_abs;
	logic [21:0]        x3;
	logic [21:0]        x4;

	assign r4 = !v_s4 || out_ready;
	assign r3 = !v_s3 || r4;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign in_ready = r1;

	assign prod = 26'(in_item.det_a) * 26'(block_recip(cfg.block));

	always_comb begin
		qc = 15'(q_s1) * 15'(cfg.block);
		pos_full = item_s1.det_a - qc[9:0];
		cm1 = cfg.block - 5'd1;
		mirror = pos_full[4:0] > (cm1 - pos_full[4:0]);
		pos_m = mirror ? (cm1 - pos_full[4:0]) : pos_full[4:0];
		nb = 13'(item_s1.det_b) - 13'(qc[9:0]);
		nb_f = mirror ? (13'(cm1) - nb) : nb;
		nb_abs = nb_f[12] ? 13'(-nb_f) : 13'(nb_f);
	end

	always_comb begin
		x3 = 22'(mag_s2);
		for (int i = 9; i >= 5; i--) begin
			if (x3 >= (22'(cfg.ring) << i)) begin
				x3 = x3 - (22'(cfg.ring) << i);
			end
		end
		x4 = 22'(mag_s3);
		for (int i = 4; i >= 0; i--) begin
			if (x4 >= (22'(cfg.ring) << i)) begin
				x4 = x4 - (22'(cfg.ring) << i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (r1) v_s1 <= in_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
			if (r4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (r1) begin
			item_s1 <= in_item;
			q_s1 <= prod[25:16];
		end
		if (r2) begin
			item_s2 <= item_s1;
			pos_s2 <= pos_m;
			neg_s2 <= nb_f[12];
			mag_s2 <= nb_abs[11:0];
		end
		if (r3) begin
			item_s3 <= item_s2;
			pos_s3 <= pos_s2;
			neg_s3 <= neg_s2;
			mag_s3 <= x3[11:0];
		end
		if (r4) begin
			item_s4 <= item_s3;
			pos_s4 <= pos_s3;
			neg_s4 <= neg_s3;
			rem_s4 <= x4[10:0];
		end
	end

	assign out_valid = v_s4;
	assign out_addr.item = item_s4;
	assign out_addr.pos = pos_s4;
	assign out_addr.neg = neg_s4;
	assign out_addr.rem = rem_s4;

endmodule

// ----- rtl/gfn_fetch.sv -----
module gfn_fetch
	import gfn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  addr_t    in_addr,
	output logic     out_valid,
	input  logic     out_ready,
	output operand_t out_op
);

	localparam int DEPTH = MAX_DETECTORS * MAX_GEO_ROWS;
	localparam int AW = $clog2(DEPTH);

	logic          v_s5;
	logic          r5;
	logic [1:0]    cmd_s5;
	logic [31:0]   value_s5;
	logic [10:0]   col;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic          in_range;
	logic          we;
	logic [31:0]   rdata;

	assign r5 = !v_s5 || out_ready;
	assign in_ready = r5;

	always_comb begin
		col = (in_addr.neg && in_addr.rem != 11'd0) ? (cfg.ring - in_addr.rem) : in_addr.rem;
		raddr = AW'(32'(in_addr.pos) * MAX_DETECTORS + 32'(col));
		waddr = AW'(32'(in_addr.item.table_row) * MAX_DETECTORS + 32'(in_addr.item.table_col));
		in_range = (32'(in_addr.item.table_row) < MAX_GEO_ROWS)
			&& (32'(in_addr.item.table_col) < MAX_DETECTORS);
		we = r5 && in_valid && in_addr.item.cmd == CMD_LOAD && in_range;
	end

	gfn_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_table (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(in_addr.item.table_word),
		.re(r5),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (r5) begin
			v_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (r5) begin
			cmd_s5 <= in_addr.item.cmd;
			value_s5 <= in_addr.item.pair_value;
		end
	end

	assign out_valid = v_s5;
	assign out_op.cmd = cmd_s5;
	assign out_op.value = value_s5;
	assign out_op.factor = rdata;

endmodule

// ----- rtl/gfn_arith.sv -----
module gfn_arith
	import gfn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  operand_t    in_op,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_value,
	output logic [1:0]  out_status
);

	localparam int NS = DIV_STEPS + 2;

	logic        vld_s [0:NS-1];
	logic        rdy   [0:NS];
	logic [1:0]  cmd_s1;
	logic [31:0] f_s1;
	logic        zero_s1;
	logic [63:0] prod_s1;
	logic [48:0] dvd_s1;
	div_t        div_s [0:DIV_STEPS];

	logic [63:0] mul_r;
	logic [16:0] hi;
	logic        sat_d;
	div_t        head;

	assign rdy[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_rdy
		assign rdy[k] = !vld_s[k] || rdy[k+1];
	end
	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	for (genvar k = 1; k < NS; k++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			cmd_s1 <= in_op.cmd;
			f_s1 <= in_op.factor;
			zero_s1 <= in_op.value == 32'd0;
			prod_s1 <= 64'(in_op.value) * 64'(in_op.factor);
			dvd_s1 <= 49'({in_op.value, 16'h0000}) + 49'(in_op.factor[31:1]);
		end
	end

	always_comb begin
		mul_r = prod_s1 + 64'h0000_0000_0000_8000;
		hi = dvd_s1[48:32];
		sat_d = 32'(hi) >= f_s1;
		head.active = 1'b0;
		head.f = f_s1;
		head.rem = 32'(hi);
		head.dq = dvd_s1[31:0];
		head.res = 32'd0;
		head.st = ST_OK;
		if (!zero_s1) begin
			if (cmd_s1 == CMD_APPLY) begin
				if (mul_r[63:48] != 16'd0) begin
					head.res = 32'hFFFF_FFFF;
					head.st = ST_SAT;
				end else begin
					head.res = mul_r[47:16];
				end
			end else if (cmd_s1 == CMD_REMOVE) begin
				if (f_s1 == 32'd0) begin
					head.res = 32'hFFFF_FFFF;
					head.st = ST_DIV0;
				end else if (sat_d) begin
					head.res = 32'hFFFF_FFFF;
					head.st = ST_SAT;
				end else begin
					head.active = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			div_s[0] <= head;
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		logic [32:0] t;
		logic        ge;
		div_t        nxt;

		always_comb begin
			t = {div_s[k-1].rem, div_s[k-1].dq[31]};
			ge = t >= {1'b0, div_s[k-1].f};
			nxt = div_s[k-1];
			nxt.rem = ge ? 32'(t - {1'b0, div_s[k-1].f}) : t[31:0];
			nxt.dq = {div_s[k-1].dq[30:0], ge};
		end

		always_ff @(posedge clk) begin
			if (rdy[k+1]) begin
				div_s[k] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_value = div_s[DIV_STEPS].active ? div_s[DIV_STEPS].dq : div_s[DIV_STEPS].res;
	assign out_status = div_s[DIV_STEPS].st;

endmodule

// ----- rtl/geometric_factor_normalise.sv -----
// Geometric normalization of detector-pair counts against a factor table.
// Items enter on the items channel and leave on the results channel; both
// use a valid/ready handshake and every item gives exactly one result, in order.
// A load item writes one table word, an apply item multiplies its count by
// the factor of its detector pair, and a remove item divides by it.
// The ring size and block size registers sit on the APB port and must be
// written only while no item is in flight; the block does not enforce it.
// One item is taken in every cycle while the receiver does not stall.
// Four stages fold the detector pair into a table address, one stage reads
// the table memory, two stages do the multiply and set up the divide, and
// the restoring divider takes one quotient bit per stage over 32 stages.
// When the receiver stalls, the last stage holds its result and the stages
// behind it keep filling until the pipeline is full; nothing is lost.
// Reset clears all valid bits and sets the ring size to 512 and the block
// size to 16. The table memory is not cleared and must be loaded first.
module geometric_factor_normalise
	import gfn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	gfn_item_if.sink    items,
	gfn_result_if.source results
);

	logic [10:0] ring_q;
	logic [4:0]  block_q;
	logic [4:0]  block_even;
	cfg_t        cfg;
	item_t       in_item;
	logic        addr_valid, addr_ready;
	addr_t       addr_data;
	logic        op_valid, op_ready;
	operand_t    op_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BLOCK) ? {27'd0, block_q} : {21'd0, ring_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= 11'd512;
			block_q <= 5'd16;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_RING) begin
				ring_q <= pwdata[10:0];
			end else begin
				block_q <= pwdata[4:0];
			end
		end
	end

	always_comb begin
		cfg.ring = ring_q;
		if (ring_q < 11'd4) begin
			cfg.ring = 11'd4;
		end else if (32'(ring_q) > MAX_DETECTORS) begin
			cfg.ring = 11'(MAX_DETECTORS);
		end
		block_even = block_q & 5'b11110;
		cfg.block = block_even;
		if (block_even < 5'd2) begin
			cfg.block = 5'd2;
		end else if (32'(block_even) > 2 * MAX_GEO_ROWS) begin
			cfg.block = 5'(2 * MAX_GEO_ROWS);
		end
	end

	always_comb begin
		in_item.cmd = items.cmd;
		in_item.det_a = items.det_a;
		in_item.det_b = items.det_b;
		in_item.pair_value = items.pair_value;
		in_item.table_row = items.table_row;
		in_item.table_col = items.table_col;
		in_item.table_word = items.table_word;
	end

	gfn_addr u_addr (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(items.valid),
		.in_ready(items.ready),
		.in_item(in_item),
		.out_valid(addr_valid),
		.out_ready(addr_ready),
		.out_addr(addr_data)
	);

	gfn_fetch u_fetch (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(addr_valid),
		.in_ready(addr_ready),
		.in_addr(addr_data),
		.out_valid(op_valid),
		.out_ready(op_ready),
		.out_op(op_data)
	);

	gfn_arith u_arith (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(op_valid),
		.in_ready(op_ready),
		.in_op(op_data),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.out_value(results.out_value),
		.out_status(results.out_status)
	);

endmodule

// ----- rtl/gfn_checker.sv -----
module gfn_checker
	import gfn_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_value,
	input logic [1:0]  res_status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_value) && $stable(res_status))
		else $error("result changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_status == ST_OK || res_status == ST_SAT || res_status == ST_DIV0))
		else $error("unknown status code");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == ST_SAT || res_status == ST_DIV0)
			|-> res_value == 32'hFFFF_FFFF)
		else $error("saturated or zero-factor result is not all ones");

	a_rdback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == REG_RING) ##1 (paddr[2] == REG_RING)
			|-> prdata == 32'($past(pwdata[10:0])))
		else $error("ring size readback mismatch");

endmodule

bind geometric_factor_normalise gfn_checker u_gfn_checker (
	.clk(clk),
	.arst_n(arst_n),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata),
	.res_valid(results.valid),
	.res_ready(results.ready),
	.res_value(results.out_value),
	.res_status(results.out_status)
);
